/* rtl/rrx_pkg.sv */
// rrx_pkg: shared types and constants for the rip-relative reference scanner
// used by every module under rtl; depends on nothing

package rrx_pkg;

    localparam int HIST_DEPTH = 6;

    typedef logic [7:0]  byte_t;
    typedef logic [63:0] addr_t;
    typedef logic [HIST_DEPTH-1:0][7:0] hist_t;   // [0] newest, [HIST_DEPTH-1] oldest

    // candidate encoding
    localparam logic [4:0] REX_W_HI    = 5'b01001;   // 0x48..0x4f share these bits
    localparam int         REX_R_BIT   = 2;
    localparam byte_t      OPC_LEA     = 8'h8D;
    localparam byte_t      OPC_MOV     = 8'h8B;
    localparam byte_t      MODRM_MASK  = 8'hC7;
    localparam byte_t      MODRM_RIP   = 8'h05;
    localparam addr_t      SITE_OFFSET = 64'd6;

    // hit count doubles as the reported status
    localparam logic [1:0] STATUS_NONE   = 2'd0;
    localparam logic [1:0] STATUS_UNIQUE = 2'd1;
    localparam logic [1:0] STATUS_AMBIG  = 2'd2;

    // configuration register indexes
    localparam logic REG_TARGET_ADDR = 1'b0;

    typedef struct packed {
        logic       hit;
        logic [3:0] dest_reg;
        logic       is_lea;
    } match_t;

    typedef struct packed {
        logic [1:0] status;
        addr_t      site;
        logic [3:0] dest_reg;
        logic       is_lea;
    } result_t;

endpackage

/* rtl/rrx_cell.sv */
// rrx_cell: one byte of the history chain with its valid flag
// depends on rrx_pkg

module rrx_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift,
    input  logic          flush,
    input  rrx_pkg::byte_t byte_in,
    input  logic          valid_in,
    output rrx_pkg::byte_t byte_out,
    output logic          valid_out
);

    rrx_pkg::byte_t byte_reg;
    logic           valid_reg;
    logic           valid_next;

    // a flush drops whatever the neighbour hands over
    assign valid_next = valid_in & ~flush;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule

/* rtl/rrx_match.sv */
// rrx_match: tests the seven-byte candidate ending on the incoming byte
// depends on rrx_pkg

module rrx_match
(
    input  rrx_pkg::hist_t  hist,
    input  logic            hist_full,
    input  rrx_pkg::byte_t  last_byte,
    input  rrx_pkg::addr_t  byte_addr,
    input  rrx_pkg::addr_t  target_addr,
    output rrx_pkg::match_t result
);

    rrx_pkg::byte_t rex;
    rrx_pkg::byte_t opc;
    rrx_pkg::byte_t modrm;
    logic [31:0]    disp32;
    rrx_pkg::addr_t dest;
    logic           form_ok;

    assign rex    = hist[rrx_pkg::HIST_DEPTH-1];
    assign opc    = hist[rrx_pkg::HIST_DEPTH-2];
    assign modrm  = hist[rrx_pkg::HIST_DEPTH-3];
    assign disp32 = {last_byte, hist[0], hist[1], hist[2]};

    assign form_ok = (rex[7:3] == rrx_pkg::REX_W_HI)
                   && ((opc == rrx_pkg::OPC_LEA) || (opc == rrx_pkg::OPC_MOV))
                   && ((modrm & rrx_pkg::MODRM_MASK) == rrx_pkg::MODRM_RIP);

    // next instruction starts one byte past the displacement
    assign dest = byte_addr + 64'd1 + {{32{disp32[31]}}, disp32};

    always_comb
    begin
        result.hit      = hist_full && form_ok && (dest == target_addr);
        result.dest_reg = {rex[rrx_pkg::REX_R_BIT], modrm[5:3]};
        result.is_lea   = (opc == rrx_pkg::OPC_LEA);
    end

endmodule

/* rtl/rrx_outq.sv */
// rrx_outq: two-entry result queue, output register plus skid register
// depends on rrx_pkg

module rrx_outq
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rrx_pkg::result_t push_item,
    input  logic             out_stall,
    output logic             out_valid,
    output rrx_pkg::result_t out_item,
    output logic             full
);

    rrx_pkg::result_t head_reg;
    rrx_pkg::result_t skid_reg;
    logic             head_valid_reg;
    logic             skid_valid_reg;
    logic             pop;

    assign pop = head_valid_reg & ~out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (push && !pop)
            begin
                if (head_valid_reg)
                begin
                    skid_valid_reg <= 1'b1;
                end
                head_valid_reg <= 1'b1;
            end
            else if (pop && !push)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    head_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !pop)
        begin
            if (head_valid_reg)
            begin
                skid_reg <= push_item;
            end
            else
            begin
                head_reg <= push_item;
            end
        end
        else if (pop && !push)
        begin
            if (skid_valid_reg)
            begin
                head_reg <= skid_reg;
            end
        end
        else if (pop && push)
        begin
            if (skid_valid_reg)
            begin
                head_reg <= skid_reg;
                skid_reg <= push_item;
            end
            else
            begin
                head_reg <= push_item;
            end
        end
    end

    assign out_valid = head_valid_reg;
    assign out_item  = head_reg;
    assign full      = skid_valid_reg;

endmodule

/* rtl/rip_relative_xref_scanner.sv */
// rip_relative_xref_scanner: top level, history chain, hit tally and register port
// depends on rrx_pkg, rrx_cell, rrx_match and rrx_outq

// Code bytes arrive on the input channel (in_valid / in_stall), one item per
// byte with its absolute address and the window_first, scan_first and
// scan_last marks. A row of six byte cells holds the bytes before the current
// one; each accepted byte shifts the row and completes a seven-byte candidate
// that is decoded, resolved and compared with target_addr in the same cycle.
// One byte is taken every cycle while in_stall is low; the cell row shift sets the rate.
// An item marked scan_last gives one result item on the output channel
// (out_valid / out_stall), written to the result queue: status (none,
// unique, ambiguous), site of the unique hit, destination register and lea
// flag of the first hit. Results wait in an output register with a skid
// register behind it; in_stall rises only while both hold a result, so bytes
// keep flowing while a single result waits to be taken.
// target_addr is written over the APB-style port at address 0; write it only
// while the block is idle. Reset clears the history, the hit tally, the
// capture, the result queue and target_addr.

module rip_relative_xref_scanner
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  code_byte,
    input  logic [63:0] byte_addr,
    input  logic        window_first,
    input  logic        scan_first,
    input  logic        scan_last,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  ref_status,
    output logic [63:0] ref_site,
    output logic [3:0]  dest_reg,
    output logic        is_lea
);

    rrx_pkg::addr_t   target_addr_reg;
    logic             in_acc;
    logic             flush;
    logic             queue_full;

    rrx_pkg::hist_t   hist;
    logic [rrx_pkg::HIST_DEPTH-1:0] hist_valid;
    logic             hist_full;
    rrx_pkg::match_t  match;

    logic [1:0]       cnt_reg;
    rrx_pkg::addr_t   site_reg;
    logic [3:0]       reg_reg;
    logic             lea_reg;
    logic [1:0]       cnt_next;
    rrx_pkg::addr_t   site_next;
    logic [3:0]       reg_next;
    logic             lea_next;

    rrx_pkg::result_t res_item;
    rrx_pkg::result_t out_item;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[3] == rrx_pkg::REG_TARGET_ADDR) ? target_addr_reg : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_addr_reg <= 64'd0;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[3] == rrx_pkg::REG_TARGET_ADDR))
        begin
            target_addr_reg <= pwdata;
        end
    end

    assign in_stall = queue_full;
    assign in_acc   = in_valid & ~in_stall;
    assign flush    = window_first | scan_first;

    // history row, cell 0 takes the incoming byte
    genvar k;
    generate
        for (k = 0; k < rrx_pkg::HIST_DEPTH; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                rrx_cell u_cell
                (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift     (in_acc),
                    .flush     (1'b0),
                    .byte_in   (code_byte),
                    .valid_in  (1'b1),
                    .byte_out  (hist[k]),
                    .valid_out (hist_valid[k])
                );
            end
            else
            begin : g_body
                rrx_cell u_cell
                (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift     (in_acc),
                    .flush     (flush),
                    .byte_in   (hist[k-1]),
                    .valid_in  (hist_valid[k-1]),
                    .byte_out  (hist[k]),
                    .valid_out (hist_valid[k])
                );
            end
        end
    endgenerate

    // oldest cell valid means the window holds six bytes already
    assign hist_full = hist_valid[rrx_pkg::HIST_DEPTH-1] & ~flush;

    rrx_match u_match
    (
        .hist        (hist),
        .hist_full   (hist_full),
        .last_byte   (code_byte),
        .byte_addr   (byte_addr),
        .target_addr (target_addr_reg),
        .result      (match)
    );

    // hit tally and first-hit capture
    always_comb
    begin
        if (scan_first)
        begin
            cnt_next  = rrx_pkg::STATUS_NONE;
            site_next = 64'd0;
            reg_next  = 4'd0;
            lea_next  = 1'b0;
        end
        else
        begin
            cnt_next  = cnt_reg;
            site_next = site_reg;
            reg_next  = reg_reg;
            lea_next  = lea_reg;
        end
        if (match.hit)
        begin
            if (cnt_next == rrx_pkg::STATUS_NONE)
            begin
                cnt_next  = rrx_pkg::STATUS_UNIQUE;
                site_next = byte_addr - rrx_pkg::SITE_OFFSET;
                reg_next  = match.dest_reg;
                lea_next  = match.is_lea;
            end
            else
            begin
                cnt_next = rrx_pkg::STATUS_AMBIG;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= rrx_pkg::STATUS_NONE;
            site_reg <= 64'd0;
            reg_reg  <= 4'd0;
            lea_reg  <= 1'b0;
        end
        else if (in_acc)
        begin
            cnt_reg  <= cnt_next;
            site_reg <= site_next;
            reg_reg  <= reg_next;
            lea_reg  <= lea_next;
        end
    end

    always_comb
    begin
        res_item.status   = cnt_next;
        res_item.site     = (cnt_next == rrx_pkg::STATUS_UNIQUE) ? site_next : 64'd0;
        res_item.dest_reg = reg_next;
        res_item.is_lea   = lea_next;
    end

    rrx_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_acc & scan_last),
        .push_item (res_item),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item),
        .full      (queue_full)
    );

    assign ref_status = out_item.status;
    assign ref_site   = out_item.site;
    assign dest_reg   = out_item.dest_reg;
    assign is_lea     = out_item.is_lea;

    // the tally saturates at ambiguous
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("hit tally beyond ambiguous");

    // a scan's last byte always leaves a result waiting
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && scan_last |=> out_valid)
        else $error("no result after last byte of scan");

    // other bytes never create a result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !scan_last && !out_valid |=> !out_valid)
        else $error("result without last byte of scan");

    // site is only reported for a unique reference
    a_site_unique: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (ref_status != rrx_pkg::STATUS_UNIQUE) |-> ref_site == 64'd0)
        else $error("site reported without unique reference");

endmodule
